FILE: design/autokey_vigenere_codec_defines.svh
// Assertion helpers shared by the codec sources.
`ifndef AUTOKEY_VIGENERE_CODEC_DEFINES_SVH
`define AUTOKEY_VIGENERE_CODEC_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("autokey codec check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ACV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("autokey codec check failed");

`endif

FILE: design/acv_pkg.sv
package acv_pkg;

    // Key ring geometry.
    localparam int MAX_KEY_LENGTH = 16;
    localparam int POS_W = (MAX_KEY_LENGTH > 1) ? $clog2(MAX_KEY_LENGTH) : 1;
    localparam int LEN_W = $clog2(MAX_KEY_LENGTH + 1);

    // Field widths.
    localparam int BYTE_W     = 8;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_LEN_W  = 5;
    localparam int KEYWORD_BYTES = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ENCODE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DECODE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd2;

    // Register reset values.
    localparam logic [CFG_LEN_W-1:0]  KEY_LENGTH_RST = 5'd1;
    localparam logic [CFG_DATA_W-1:0] KEY_LOW_RST    = 64'd65;
    localparam logic [CFG_DATA_W-1:0] KEY_HIGH_RST   = 64'd0;

    // Character constants.
    localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_Z     = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_BIT   = 8'h20;
    localparam logic [5:0]        ALPHABET   = 6'd26;

    // Output buffer geometry.
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = 2;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [MAX_KEY_LENGTH-1:0][BYTE_W-1:0] t_key_bytes;

    function automatic logic is_lower(input t_byte c);
        return (c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z);
    endfunction

    function automatic t_byte up_case(input t_byte c);
        return is_lower(c) ? (c - CASE_BIT) : c;
    endfunction

    // True for a letter of either case.
    function automatic logic is_letter(input t_byte c);
        t_byte u;
        u = up_case(c);
        return (u >= CHAR_A) && (u <= CHAR_Z);
    endfunction

    // Spread the two keyword registers over the ring; bytes past the
    // keyword load as zero.
    function automatic t_key_bytes unpack_keyword(input logic [CFG_DATA_W-1:0] lo,
                                                  input logic [CFG_DATA_W-1:0] hi);
        t_key_bytes kb;
        logic [2*CFG_DATA_W-1:0] word;
        word = {hi, lo};
        for (int i = 0; i < MAX_KEY_LENGTH; i++) begin
            if (i < KEYWORD_BYTES) begin
                kb[i] = word[BYTE_W*i +: BYTE_W];
            end else begin
                kb[i] = '0;
            end
        end
        return kb;
    endfunction

    // Stage-one state of a request whose ring entry is being read.
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        t_byte             ch;
        logic [POS_W-1:0]  pos;
        logic              adv;
        logic              use_ram;
        t_byte             alt;
    } t_stage;

endpackage

FILE: design/acv_if.sv
// Input request channel.
interface acv_in_if;
    logic                        valid;
    logic                        ready;
    logic [acv_pkg::OP_W-1:0]    op;
    logic [acv_pkg::BYTE_W-1:0]  char_in;

    modport source (output valid, output op, output char_in, input ready);
    modport sink   (input valid, input op, input char_in, output ready);
endinterface

// Result channel.
interface acv_out_if;
    logic                        valid;
    logic                        ready;
    logic [acv_pkg::BYTE_W-1:0]  char_out;
    logic [acv_pkg::BYTE_W-1:0]  key_used;

    modport source (output valid, output char_out, output key_used, input ready);
    modport sink   (input valid, input char_out, input key_used, output ready);
endinterface

// Register write channel.
interface acv_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [acv_pkg::CFG_IDX_W-1:0]   index;
    logic [acv_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/acv_ram.sv
module acv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; a read of the entry being written returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/autokey_vigenere_codec.sv
// Autokey Vigenere codec: one character request per clock while the request
// side is ready, every request giving exactly one result. The key ring sits
// in a 16 x 8 RAM with a registered read; each request reads its entry in the
// accept cycle, and one that advanced the ring writes the recovered plaintext
// back in the next cycle, so the single RAM read and write port set the rate
// of one request a cycle. A restart snapshots the keyword registers and
// clears one valid bit per ring entry, so entries not yet overwritten read
// from the snapshot. Results wait in a three-entry buffer; the request side
// stays ready while that buffer, counting the result in stage one, has room,
// and register writes are always taken and apply at the next restart.
`include "autokey_vigenere_codec_defines.svh"

module autokey_vigenere_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acv_cfg_if.sink    i_cfg,
    acv_in_if.sink     i_in,
    acv_out_if.source  o_out
);

    localparam int MAXK  = acv_pkg::MAX_KEY_LENGTH;
    localparam int POS_W = acv_pkg::POS_W;
    localparam int LEN_W = acv_pkg::LEN_W;
    localparam int BW    = acv_pkg::BYTE_W;

    // Configuration registers.
    logic [acv_pkg::CFG_LEN_W-1:0]  r_cfg_len;
    logic [acv_pkg::CFG_DATA_W-1:0] r_cfg_low;
    logic [acv_pkg::CFG_DATA_W-1:0] r_cfg_high;

    // Ring control state.
    acv_pkg::t_key_bytes r_snap;
    logic [MAXK-1:0]     r_valid;
    logic [LEN_W-1:0]    r_len;
    logic [POS_W-1:0]    r_pos;
    logic [LEN_W-1:0]    n_len;
    logic [POS_W-1:0]    n_pos;

    // Stage one.
    acv_pkg::t_stage r_s1;
    acv_pkg::t_stage n_s1;

    // Result buffer.
    acv_pkg::t_byte            r_buf_char [acv_pkg::OUT_DEPTH];
    acv_pkg::t_byte            r_buf_key  [acv_pkg::OUT_DEPTH];
    logic [acv_pkg::OUT_PTR_W-1:0] r_wr_ptr;
    logic [acv_pkg::OUT_PTR_W-1:0] r_rd_ptr;
    logic [acv_pkg::OUT_PTR_W-1:0] r_cnt;

    logic           in_fire;
    logic           out_fire;
    logic           restart;
    logic           s1_we;
    logic           hit;
    acv_pkg::t_byte snap_byte;
    acv_pkg::t_byte ram_q;
    acv_pkg::t_byte key_raw;
    acv_pkg::t_byte w_plain;
    acv_pkg::t_byte res_char;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = ({1'b0, r_cnt} + {2'b0, r_s1.valid}) < 3'(acv_pkg::OUT_DEPTH);
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_fire    = o_out.valid && o_out.ready;
    assign restart     = in_fire && (i_in.op == acv_pkg::OP_RESTART);

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len  <= acv_pkg::KEY_LENGTH_RST;
            r_cfg_low  <= acv_pkg::KEY_LOW_RST;
            r_cfg_high <= acv_pkg::KEY_HIGH_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                acv_pkg::REG_KEY_LENGTH: begin
                    r_cfg_len <= i_cfg.data[acv_pkg::CFG_LEN_W-1:0];
                end
                acv_pkg::REG_KEY_LOW: begin
                    r_cfg_low <= i_cfg.data;
                end
                acv_pkg::REG_KEY_HIGH: begin
                    r_cfg_high <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    // Stage one writes back when its request advanced the ring.
    assign s1_we = r_s1.valid && r_s1.adv;
    assign hit   = s1_we && (r_s1.pos == r_pos);
    assign snap_byte = r_snap[r_pos];

    // Accept stage: decide the advance from letter flags, pick the key source.
    always_comb begin
        logic key_letter;
        logic len_big;
        key_letter = r_valid[r_pos] || hit || acv_pkg::is_letter(snap_byte);
        len_big    = int'(r_cfg_len) > MAXK;

        n_s1.valid   = in_fire;
        n_s1.op      = i_in.op;
        n_s1.ch      = i_in.char_in;
        n_s1.pos     = r_pos;
        n_s1.adv     = ((i_in.op == acv_pkg::OP_ENCODE) || (i_in.op == acv_pkg::OP_DECODE))
                       && key_letter && acv_pkg::is_letter(i_in.char_in);
        n_s1.use_ram = r_valid[r_pos] && !hit;
        n_s1.alt     = hit ? w_plain : snap_byte;

        // Length latched on restart, out-of-range values clamped.
        if (r_cfg_len == '0) begin
            n_len = LEN_W'(1);
        end else if (len_big) begin
            n_len = LEN_W'(MAXK);
        end else begin
            n_len = LEN_W'(r_cfg_len);
        end

        // Position steps around the ring.
        if ((LEN_W'(r_pos) + LEN_W'(1)) == r_len) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    // Ring control registers; a restart discards the write-back marks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap  <= acv_pkg::unpack_keyword(acv_pkg::KEY_LOW_RST, acv_pkg::KEY_HIGH_RST);
            r_valid <= '0;
            r_len   <= LEN_W'(acv_pkg::KEY_LENGTH_RST);
            r_pos   <= '0;
        end else if (restart) begin
            r_snap  <= acv_pkg::unpack_keyword(r_cfg_low, r_cfg_high);
            r_valid <= '0;
            r_len   <= n_len;
            r_pos   <= '0;
        end else begin
            if (s1_we) begin
                r_valid[r_s1.pos] <= 1'b1;
            end
            if (in_fire && n_s1.adv) begin
                r_pos <= n_pos;
            end
        end
    end

    // Stage-one register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    // Key ring storage.
    acv_ram #(
        .WIDTH (BW),
        .DEPTH (MAXK)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (s1_we),
        .i_waddr (r_s1.pos),
        .i_wdata (w_plain),
        .i_re    (in_fire),
        .i_raddr (r_pos),
        .o_rdata (ram_q)
    );

    // Stage one: cipher arithmetic on the letter indices.
    always_comb begin
        acv_pkg::t_byte key_up;
        acv_pkg::t_byte ch_up;
        acv_pkg::t_byte k_off;
        acv_pkg::t_byte p_off;
        logic [5:0]     sum;
        logic [4:0]     m;
        acv_pkg::t_byte upper;

        key_raw = r_s1.use_ram ? ram_q : r_s1.alt;
        key_up  = acv_pkg::up_case(key_raw);
        ch_up   = acv_pkg::up_case(r_s1.ch);
        k_off   = key_up - acv_pkg::CHAR_A;
        p_off   = ch_up - acv_pkg::CHAR_A;

        if (r_s1.op == acv_pkg::OP_ENCODE) begin
            sum = {1'b0, k_off[4:0]} + {1'b0, p_off[4:0]} + 6'd1;
        end else begin
            sum = {1'b0, p_off[4:0]} + 6'd25 - {1'b0, k_off[4:0]};
        end
        if (sum >= acv_pkg::ALPHABET) begin
            sum = sum - acv_pkg::ALPHABET;
        end
        m     = sum[4:0];
        upper = acv_pkg::CHAR_A + {3'b0, m};

        w_plain = (r_s1.op == acv_pkg::OP_ENCODE) ? ch_up : upper;

        if (r_s1.op == acv_pkg::OP_RESTART) begin
            res_char = '0;
        end else if (r_s1.adv) begin
            res_char = acv_pkg::is_lower(r_s1.ch) ? (upper | acv_pkg::CASE_BIT) : upper;
        end else begin
            res_char = r_s1.ch;
        end
    end

    // Result buffer.
    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            r_buf_char[r_wr_ptr] <= res_char;
            r_buf_key[r_wr_ptr]  <= key_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_s1.valid) begin
                r_wr_ptr <= (r_wr_ptr == acv_pkg::OUT_PTR_W'(acv_pkg::OUT_DEPTH - 1))
                            ? '0 : r_wr_ptr + acv_pkg::OUT_PTR_W'(1);
            end
            if (out_fire) begin
                r_rd_ptr <= (r_rd_ptr == acv_pkg::OUT_PTR_W'(acv_pkg::OUT_DEPTH - 1))
                            ? '0 : r_rd_ptr + acv_pkg::OUT_PTR_W'(1);
            end
            r_cnt <= r_cnt + acv_pkg::OUT_PTR_W'(r_s1.valid) - acv_pkg::OUT_PTR_W'(out_fire);
        end
    end

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.char_out = r_buf_char[r_rd_ptr];
    assign o_out.key_used = r_buf_key[r_rd_ptr];

    // Checks.
    `ACV_ASSERT_IMP(a_buf_bound, i_clk, i_rst_n, 1'b1, r_cnt <= acv_pkg::OUT_PTR_W'(acv_pkg::OUT_DEPTH))
    `ACV_ASSERT_IMP(a_pos_in_ring, i_clk, i_rst_n, 1'b1, LEN_W'(r_pos) < r_len)
    `ACV_ASSERT_NXT(a_restart_clears, i_clk, i_rst_n, restart, (r_pos == '0) && (r_valid == '0))

endmodule
